[sv/mwc_pkg.sv]
// mwc_pkg: shared constants, codes and types of the minimum window cover block
// no dependencies; imported by the interfaces, every module and the checker
package mwc_pkg;

   localparam int MAX_LEN  = 4096;
   localparam int ALPHABET = 128;

   localparam int PTR_W   = $clog2(MAX_LEN);
   localparam int CNT_W   = PTR_W + 1;
   localparam int CODE_W  = 7;
   localparam int ALPHA_W = $clog2(ALPHABET);
   localparam int NEED_W  = 14;
   localparam int MISS_W  = 13;
   localparam int OP_W    = 2;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = Q_PTR_W + 1;

   localparam logic [MISS_W-1:0] MISSING_MAX = MISS_W'((2 ** MISS_W) - 1);

   // request op codes
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_TARGET = 2'd1;
   localparam logic [OP_W-1:0] OP_SOURCE = 2'd2;

   typedef enum logic [1:0] {
      CMD_CLEAR,
      CMD_TARGET,
      CMD_SOURCE,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [CODE_W-1:0] code;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_TGT_UPD,
      BK_SRC_UPD,
      BK_SH_CMP,
      BK_SH_RD,
      BK_SH_UPD,
      BK_RESP
   } back_state_type;

endpackage

[sv/mwc_req_if.sv]
// mwc_req_if: request channel of the minimum window cover block
// depends on mwc_pkg for field widths
interface mwc_req_if import mwc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [CODE_W-1:0] char_code;

   modport source (output valid, output op, output char_code, input ready);
   modport sink   (input valid, input op, input char_code, output ready);
endinterface

[sv/mwc_rsp_if.sv]
// mwc_rsp_if: response channel of the minimum window cover block
// depends on mwc_pkg for field widths
interface mwc_rsp_if import mwc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             found;
   logic [PTR_W-1:0] best_start;
   logic [CNT_W-1:0] best_len;
   logic             overflow;

   modport source (output valid, output found, output best_start, output best_len,
                   output overflow, input ready);
   modport sink   (input valid, input found, input best_start, input best_len,
                   input overflow, output ready);
endinterface

[sv/minimum_window_cover.sv]
// channel   dir  handshake      payload
// req_chan  in   valid/ready    op[1:0], char_code[6:0]
// rsp_chan  out  valid/ready    found, best_start[11:0], best_len[12:0], overflow
//
// in the back end a clear, a no-op, an ignored target or a source character dropped
// on a full buffer passes the idle and response states; a counted target or a
// stored source character also passes an update state, and every position the
// window start advances adds buffer read, table read and table update; each source
// character leaves the window at most once; a stalled response adds its wait
// a 4-entry command queue takes requests while the back end works or the
// response register waits; reset is synchronous and needs no clearing pass
// top level: connects front end, command queue and back end
// depends on mwc_pkg, mwc_req_if, mwc_rsp_if, mwc_front, mwc_back
module minimum_window_cover import mwc_pkg::*; (
   input logic       clock,
   input logic       reset,
   mwc_req_if.sink   req_chan,
   mwc_rsp_if.source rsp_chan
);

   queue_head_type head;
   logic           pop;

   mwc_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .pop   (pop),
      .head  (head)
   );

   mwc_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule

[sv/mwc_front.sv]
// mwc_front: accepts requests, decodes them into commands and queues them
// depends on mwc_pkg and mwc_req_if
module mwc_front import mwc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   mwc_req_if.sink        req,
   input  logic           pop,
   output queue_head_type head
);

   cmd_type              q_mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 push;
   logic                 pop_ok;
   logic                 code_ok;
   cmd_type              cmd;

   assign req.ready = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign push      = req.valid && req.ready;
   assign pop_ok    = pop && (count_ff != '0);

   // codes outside the alphabet turn into no-ops
   assign code_ok = (32'(req.char_code) < ALPHABET);

   always_comb begin
      cmd.code = req.char_code;
      unique case (req.op)
         OP_CLEAR:  cmd.kind = CMD_CLEAR;
         OP_TARGET: cmd.kind = code_ok ? CMD_TARGET : CMD_NOP;
         OP_SOURCE: cmd.kind = code_ok ? CMD_SOURCE : CMD_NOP;
         default:   cmd.kind = CMD_NOP;
      endcase
   end

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop_ok) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (pop_ok && !push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = q_mem_ff[rd_ptr_ff];

endmodule

[sv/mwc_back.sv]
// mwc_back: sequencer that runs queued commands against the count table and
// the source buffer, and holds the response register; depends on mwc_pkg, mwc_rsp_if
module mwc_back import mwc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   mwc_rsp_if.source      rsp
);

   back_state_type state_ff, state_in;

   logic [MISS_W-1:0]  missing_ff, missing_in;
   logic [CNT_W-1:0]   start_ff, start_in;
   logic [CNT_W-1:0]   end_ff, end_in;
   logic [PTR_W-1:0]   best_start_ff, best_start_in;
   logic [CNT_W-1:0]   best_len_ff, best_len_in;
   logic               ovf_ff, ovf_in;
   logic [ALPHABET-1:0] need_vld_ff, need_vld_in;
   logic [ALPHA_W-1:0] code_ff, code_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [PTR_W-1:0]   rsp_start_ff, rsp_start_in;
   logic [CNT_W-1:0]   rsp_len_ff, rsp_len_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   // count table and source buffer
   logic signed [NEED_W-1:0] need_mem [ALPHABET];
   logic signed [NEED_W-1:0] need_rdata_ff;
   logic [ALPHA_W-1:0]       need_raddr_ff;
   logic                     need_re, need_we;
   logic [ALPHA_W-1:0]       need_raddr, need_waddr;
   logic signed [NEED_W-1:0] need_wdata;
   logic signed [NEED_W-1:0] need_cur;

   logic [CODE_W-1:0]  src_mem [MAX_LEN];
   logic [CODE_W-1:0]  src_rdata_ff;
   logic               src_we, src_re;

   logic [CNT_W-1:0]   win_len;
   logic               src_hit;
   logic               src_covers;
   logic               shrink_more;
   logic               rsp_load;
   logic               buf_full;
   logic               tgt_ok;

   // entries not written since the last clear read as zero
   assign need_cur = need_vld_ff[need_raddr_ff] ? need_rdata_ff : '0;

   assign win_len     = end_ff - start_ff;
   assign src_hit     = (missing_ff != '0) && (need_cur > 0);
   assign src_covers  = src_hit && (missing_ff == MISS_W'(1));
   assign shrink_more = need_cur[NEED_W-1] && ((start_ff + CNT_W'(1)) < end_ff);
   assign rsp_load    = !rsp_valid_ff || rsp.ready;
   assign buf_full    = (end_ff == CNT_W'(MAX_LEN));
   assign tgt_ok      = (missing_ff != MISSING_MAX);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (head.valid) begin
               unique case (head.cmd.kind)
                  CMD_TARGET: state_in = tgt_ok ? BK_TGT_UPD : BK_RESP;
                  CMD_SOURCE: state_in = buf_full ? BK_RESP : BK_SRC_UPD;
                  CMD_CLEAR:  state_in = BK_RESP;
                  CMD_NOP:    state_in = BK_RESP;
                  default:    state_in = BK_RESP;
               endcase
            end
         end
         BK_TGT_UPD: state_in = BK_RESP;
         BK_SRC_UPD: state_in = src_covers ? BK_SH_CMP : BK_RESP;
         BK_SH_CMP:  state_in = BK_SH_RD;
         BK_SH_RD:   state_in = BK_SH_UPD;
         BK_SH_UPD:  state_in = shrink_more ? BK_SH_CMP : BK_RESP;
         BK_RESP:    state_in = rsp_load ? BK_IDLE : BK_RESP;
         default:    state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop           = 1'b0;
      missing_in    = missing_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      best_start_in = best_start_ff;
      best_len_in   = best_len_ff;
      ovf_in        = ovf_ff;
      need_vld_in   = need_vld_ff;
      code_in       = code_ff;
      need_re       = 1'b0;
      need_raddr    = code_ff;
      need_we       = 1'b0;
      need_waddr    = code_ff;
      need_wdata    = need_cur;
      src_we        = 1'b0;
      src_re        = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_found_in  = rsp_found_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (head.valid) begin
               pop        = 1'b1;
               code_in    = head.cmd.code[ALPHA_W-1:0];
               need_raddr = head.cmd.code[ALPHA_W-1:0];
               unique case (head.cmd.kind)
                  CMD_CLEAR: begin
                     missing_in    = '0;
                     start_in      = '0;
                     end_in        = '0;
                     best_start_in = '0;
                     best_len_in   = '0;
                     ovf_in        = 1'b0;
                     need_vld_in   = '0;
                  end
                  CMD_TARGET: begin
                     need_re = tgt_ok;
                  end
                  CMD_SOURCE: begin
                     if (buf_full) begin
                        ovf_in = 1'b1;
                     end else begin
                        need_re = 1'b1;
                        src_we  = 1'b1;
                     end
                  end
                  CMD_NOP: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_TGT_UPD: begin
            need_we              = 1'b1;
            need_wdata           = need_cur + NEED_W'(1);
            need_vld_in[code_ff] = 1'b1;
            missing_in           = missing_ff + MISS_W'(1);
         end
         BK_SRC_UPD: begin
            need_we              = 1'b1;
            need_wdata           = need_cur - NEED_W'(1);
            need_vld_in[code_ff] = 1'b1;
            end_in               = end_ff + CNT_W'(1);
            if (src_hit) begin
               missing_in = missing_ff - MISS_W'(1);
            end
         end
         BK_SH_CMP: begin
            if ((best_len_ff == '0) || (win_len < best_len_ff)) begin
               best_start_in = start_ff[PTR_W-1:0];
               best_len_in   = win_len;
            end
            src_re = 1'b1;
         end
         BK_SH_RD: begin
            need_re    = 1'b1;
            need_raddr = src_rdata_ff[ALPHA_W-1:0];
            code_in    = src_rdata_ff[ALPHA_W-1:0];
         end
         BK_SH_UPD: begin
            need_we              = 1'b1;
            need_wdata           = need_cur + NEED_W'(1);
            need_vld_in[code_ff] = 1'b1;
            start_in             = start_ff + CNT_W'(1);
            // the count turns positive again: the window lacks this character
            if (!need_cur[NEED_W-1]) begin
               missing_in = missing_ff + MISS_W'(1);
            end
         end
         BK_RESP: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_ovf_in   = ovf_ff;
               if (best_len_ff != '0) begin
                  rsp_found_in = 1'b1;
                  rsp_start_in = best_start_ff;
                  rsp_len_in   = best_len_ff;
               end else begin
                  // empty target counts as a zero-length match
                  rsp_found_in = (missing_ff == '0);
                  rsp_start_in = '0;
                  rsp_len_in   = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         missing_ff    <= '0;
         start_ff      <= '0;
         end_ff        <= '0;
         best_start_ff <= '0;
         best_len_ff   <= '0;
         ovf_ff        <= 1'b0;
         need_vld_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         missing_ff    <= missing_in;
         start_ff      <= start_in;
         end_ff        <= end_in;
         best_start_ff <= best_start_in;
         best_len_ff   <= best_len_in;
         ovf_ff        <= ovf_in;
         need_vld_ff   <= need_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff      <= code_in;
      rsp_found_ff <= rsp_found_in;
      rsp_start_ff <= rsp_start_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (need_we) begin
         need_mem[need_waddr] <= need_wdata;
      end
      if (need_re) begin
         need_rdata_ff <= need_mem[need_raddr];
         need_raddr_ff <= need_raddr;
      end
   end

   always_ff @(posedge clock) begin
      if (src_we) begin
         src_mem[end_ff[PTR_W-1:0]] <= head.cmd.code;
      end
      if (src_re) begin
         src_rdata_ff <= src_mem[start_ff[PTR_W-1:0]];
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.found      = rsp_found_ff;
   assign rsp.best_start = rsp_start_ff;
   assign rsp.best_len   = rsp_len_ff;
   assign rsp.overflow   = rsp_ovf_ff;

endmodule

[sv/mwc_checker.sv]
// mwc_checker: port-level checks of the minimum window cover block, bound to the top
// depends on mwc_pkg and minimum_window_cover
module mwc_checker import mwc_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_found,
   input logic [PTR_W-1:0] rsp_best_start,
   input logic [CNT_W-1:0] rsp_best_len,
   input logic             rsp_overflow
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
         && $stable(rsp_best_start) && $stable(rsp_best_len) && $stable(rsp_overflow))
      else $error("response changed while stalled");

   a_len_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_best_len != '0) |-> rsp_found)
      else $error("nonzero length without found");

   a_no_len_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_best_len == '0) |-> (rsp_best_start == '0))
      else $error("start reported without a window");

   a_in_buffer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (({1'b0, rsp_best_start} + {1'b0, rsp_best_len}) <= (CNT_W + 1)'(MAX_LEN)))
      else $error("window runs past the buffer");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind minimum_window_cover mwc_checker u_mwc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_found      (rsp_chan.found),
   .rsp_best_start (rsp_chan.best_start),
   .rsp_best_len   (rsp_chan.best_len),
   .rsp_overflow   (rsp_chan.overflow)
);
